FILE: hdl/ggnh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggnh_pkg
// Shared types and codes for the greedy geographic next-hop selector.
// ----------------------------------------------------------------------------
package ggnh_pkg;

  localparam int ADDR_W   = 32;
  localparam int DIST_W   = 17;
  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_UNCHANGED = 3'd2,
    ST_OWN       = 3'd3,
    ST_FULL      = 3'd4,
    ST_HOP       = 3'd5,
    ST_DEAD      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CFG_OWN_ADDR = 2'd0,
    CFG_OWN_X    = 2'd1,
    CFG_OWN_Y    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_OWN_WAIT,
    S_DRAIN,
    S_WRITE,
    S_OUT
  } state_t;

  localparam logic OP_ADV   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

FILE: hdl/ggnh_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggnh_isqrt
// Pipelined floor square root, two result bits per stage.
// ----------------------------------------------------------------------------
module ggnh_isqrt #(
  parameter int IN_W  = 34,
  parameter int TAG_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [IN_W-1:0]      in_val,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_valid,
  output logic [(IN_W+1)/2-1:0] out_root,
  output logic [TAG_W-1:0]     out_tag
);

  localparam int RW = (IN_W + 1) / 2;
  localparam int VW = 2 * RW;
  // Each stage resolves two root bits
  localparam int NS = (RW + 1) / 2;

  logic [VW-1:0]    rem [0:NS];
  logic [RW-1:0]    root [0:NS];
  logic [VW-1:0]    rad [0:NS];
  logic [TAG_W-1:0] tag [0:NS];
  logic             vld [0:NS];

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = VW'(in_val);
  assign tag[0]  = in_tag;
  assign vld[0]  = in_valid;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [VW-1:0] rm [0:2];
    logic [RW-1:0] rt [0:2];
    logic [VW-1:0] rd [0:2];
    always_comb begin
      logic [VW+1:0] trial;
      trial = '0;
      rm[0] = rem[s];
      rt[0] = root[s];
      rd[0] = rad[s];
      for (int k = 0; k < 2; k++) begin
        if ((s * 2 + k) < RW) begin
          trial = {rm[k], rd[k][VW-1 -: 2]} - {rt[k], 2'b01};
          if (!trial[VW+1]) begin
            rm[k+1] = trial[VW-1:0];
            rt[k+1] = {rt[k][RW-2:0], 1'b1};
          end else begin
            rm[k+1] = {rm[k][VW-3:0], rd[k][VW-1 -: 2]};
            rt[k+1] = {rt[k][RW-2:0], 1'b0};
          end
          rd[k+1] = {rd[k][VW-3:0], 2'b00};
        end else begin
          rm[k+1] = rm[k];
          rt[k+1] = rt[k];
          rd[k+1] = rd[k];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rem[s+1]  <= rm[2];
      root[s+1] <= rt[2];
      rad[s+1]  <= rd[2];
      tag[s+1]  <= tag[s];
    end
  end

  assign out_valid = vld[NS];
  assign out_root  = root[NS];
  assign out_tag   = tag[NS];

endmodule

FILE: hdl/greedy_geo_next_hop.sv
`timescale 1ns / 1ps
// Advertisement: a table scan through the entry memory, then the write; route
// query: a table scan (one memory read per cycle into the pipelined square
// root), then a drain of that pipeline.
// Throughput: one item at a time; the next item is taken the cycle after the
// result leaves the output register.
// Reset (rst, synchronous): valid bits cleared, configuration registers zero, no sweep.
// ----------------------------------------------------------------------------
// greedy_geo_next_hop
// Neighbor table with greedy geographic next-hop selection.
// ----------------------------------------------------------------------------
module greedy_geo_next_hop
  import ggnh_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int COORD_BITS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              opcode,
  input  logic [31:0]       item_addr,
  input  logic [15:0]       pos_x,
  input  logic [15:0]       pos_y,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [31:0]       next_hop_addr,
  output logic [16:0]       next_hop_distance,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = IW + 1;
  localparam int CB = COORD_BITS;
  localparam int SQ = 2 * CB + 1;
  localparam int RW = (SQ + 1) / 2;
  localparam int NS = (RW + 1) / 2;
  // Tag through the root pipeline: own-position flag and neighbor address
  localparam int TW = ADDR_W + 1;
  localparam logic [TW-1:0] OWN_TAG = {1'b1, {ADDR_W{1'b0}}};

  logic [ADDR_W-1:0] own_addr;
  logic [CB-1:0]     own_x, own_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_addr <= '0;
      own_x    <= '0;
      own_y    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ADDR: own_addr <= cfg_data;
        CFG_OWN_X:    own_x    <= CB'(cfg_data[15:0]);
        CFG_OWN_Y:    own_y    <= CB'(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  // Entry memory: address and position, registered read
  logic [ADDR_W+2*CB-1:0] mem [0:TABLE_ENTRIES-1];
  logic [ADDR_W+2*CB-1:0] rd_data;
  logic [IW-1:0]          rd_idx;
  logic                   wr_en;
  logic [IW-1:0]          wr_idx;
  logic [ADDR_W+2*CB-1:0] wr_data;
  logic [TABLE_ENTRIES-1:0] valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    rd_data <= mem[rd_idx];
  end

  state_t state, state_next;
  logic              op_q;
  logic              is_query;
  logic [ADDR_W-1:0] addr_q;
  logic [CB-1:0]     px_q, py_q;
  logic [CW-1:0]     cnt;
  logic              rd_pend;
  logic [IW-1:0]     rd_pend_idx;
  logic              hit, have_free;
  logic [IW-1:0]     hit_idx, free_idx;
  logic              pos_eq;
  logic              found;
  logic [RW-1:0]     best;
  logic [ADDR_W-1:0] best_addr;
  logic [NS+1:0]     drain;
  logic              res_valid;
  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [DIST_W-1:0] res_dist;

  assign is_query = (op_q == OP_QUERY);

  logic [ADDR_W-1:0] e_addr;
  logic [CB-1:0]     e_x, e_y;
  assign e_addr = rd_data[ADDR_W+2*CB-1 -: ADDR_W];
  assign e_x    = rd_data[2*CB-1 -: CB];
  assign e_y    = rd_data[CB-1:0];

  // Squared distance stages: registered squares, then registered sum
  logic          sq_valid;
  logic [SQ-1:0] sq_val;
  logic [TW-1:0] sq_tag;
  logic [CB-1:0] ax, ay;
  logic          a_valid;
  logic [TW-1:0] a_tag;

  always_comb begin
    if (state == S_OWN_WAIT && cnt == '0) begin
      ax = own_x;
      ay = own_y;
    end else begin
      ax = e_x;
      ay = e_y;
    end
  end

  logic [CB-1:0] dx, dy;
  assign dx = (ax > px_q) ? ax - px_q : px_q - ax;
  assign dy = (ay > py_q) ? ay - py_q : py_q - ay;

  logic [2*CB-1:0] dx2, dy2;
  logic            m_valid;
  logic [TW-1:0]   m_tag;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid  <= 1'b0;
      sq_valid <= 1'b0;
    end else begin
      m_valid  <= a_valid;
      sq_valid <= m_valid;
    end
    dx2    <= dx * dx;
    dy2    <= dy * dy;
    m_tag  <= a_tag;
    sq_val <= SQ'(dx2) + SQ'(dy2);
    sq_tag <= m_tag;
  end

  logic          r_valid;
  logic [RW-1:0] r_root;
  logic [TW-1:0] r_tag;

  ggnh_isqrt #(.IN_W(SQ), .TAG_W(TW)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_val    (sq_val),
    .in_tag    (sq_tag),
    .out_valid (r_valid),
    .out_root  (r_root),
    .out_tag   (r_tag)
  );

  assign in_stall = (state != S_IDLE) || res_valid;
  assign rd_idx   = cnt[IW-1:0];

  always_comb begin
    state_next = state;
    a_valid    = 1'b0;
    a_tag      = OWN_TAG;
    case (state)
      S_IDLE:     if (in_valid && !in_stall) state_next = S_OWN_WAIT;
      S_OWN_WAIT: begin
        if (is_query) begin
          a_valid = 1'b1;
          a_tag   = OWN_TAG;
        end
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (is_query && rd_pend) begin
          a_valid = 1'b1;
          a_tag   = {1'b0, e_addr};
        end
        if (cnt == CW'(TABLE_ENTRIES) && !rd_pend) begin
          state_next = is_query ? S_DRAIN : S_WRITE;
        end
      end
      S_DRAIN:    if (drain == '0) state_next = S_OUT;
      S_WRITE:    state_next = S_IDLE;
      S_OUT:      state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  status_t adv_status;
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = free_idx;
    wr_data = {addr_q, px_q, py_q};
    if (addr_q == own_addr) begin
      adv_status = ST_OWN;
    end else if (hit) begin
      wr_idx = hit_idx;
      if (pos_eq) begin
        adv_status = ST_UNCHANGED;
      end else begin
        adv_status = ST_UPDATED;
        wr_en = (state == S_WRITE);
      end
    end else if (have_free) begin
      adv_status = ST_ADDED;
      wr_en = (state == S_WRITE);
    end else begin
      adv_status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid_q   <= '0;
      res_valid <= 1'b0;
      rd_pend   <= 1'b0;
      drain     <= '0;
    end else begin
      state <= state_next;
      if (res_valid && !out_stall) res_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          op_q      <= opcode;
          addr_q    <= item_addr;
          px_q      <= CB'(pos_x);
          py_q      <= CB'(pos_y);
          cnt       <= '0;
          hit       <= 1'b0;
          have_free <= 1'b0;
          hit_idx   <= '0;
          free_idx  <= '0;
          found     <= 1'b0;
          best      <= '0;
          best_addr <= '0;
          drain     <= '0;
        end
        S_SCAN: begin
          rd_pend <= 1'b0;
          if (cnt != CW'(TABLE_ENTRIES)) begin
            if (valid_q[cnt[IW-1:0]]) begin
              rd_pend     <= 1'b1;
              rd_pend_idx <= cnt[IW-1:0];
            end else if (!have_free) begin
              have_free <= 1'b1;
              free_idx  <= cnt[IW-1:0];
            end
            cnt <= cnt + 1'b1;
          end
          if (rd_pend && !is_query && !hit && e_addr == addr_q) begin
            hit     <= 1'b1;
            hit_idx <= rd_pend_idx;
            pos_eq  <= (e_x == px_q) && (e_y == py_q);
          end
          if (a_valid) drain <= {drain[NS:0], 1'b1};
          else drain <= {drain[NS:0], 1'b0};
        end
        S_OWN_WAIT: drain <= {drain[NS:0], a_valid};
        S_DRAIN: begin
          drain <= {drain[NS:0], 1'b0};
          if (drain == '0) begin
            res_valid  <= 1'b1;
            res_status <= found ? ST_HOP : ST_DEAD;
            res_addr   <= found ? best_addr : '0;
            res_dist   <= found ? ((RW > DIST_W && (best >> DIST_W) != '0) ?
                                   '1 : DIST_W'(best)) : '0;
          end
        end
        S_WRITE: begin
          if (wr_en) valid_q[wr_idx] <= 1'b1;
          res_valid  <= 1'b1;
          res_status <= adv_status;
          res_addr   <= '0;
          res_dist   <= '0;
        end
        default: ;
      endcase
      // Minimum tracking as roots come out of the pipeline
      if (r_valid) begin
        if (r_tag[ADDR_W]) begin
          best <= r_root;
        end else if (r_root < best || (r_root == best &&
                     (!found || r_tag[ADDR_W-1:0] < best_addr))) begin
          best      <= r_root;
          best_addr <= r_tag[ADDR_W-1:0];
          found     <= 1'b1;
        end
      end
    end
  end

  assign out_valid         = res_valid;
  assign status            = res_status;
  assign next_hop_addr     = res_addr;
  assign next_hop_distance = res_dist;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_stall) |=> res_valid) else $error("result dropped");
  a_write_adv: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_WRITE && !is_query)) else $error("stray write");
  a_hop_addr: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status != ST_HOP) |-> (res_addr == '0))
    else $error("addr without hop");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the greedy geographic next-hop selector: random
// advertisements and route queries in bursts, a table model in the bench
// predicts status, next hop and distance for every item.
// ----------------------------------------------------------------------------
module tb_top;
  import ggnh_pkg::*;

  localparam int ENTRIES   = 16;
  localparam int LIMIT_CYC = 400000;

  typedef struct packed {
    logic        op;
    logic [31:0] addr;
    logic [15:0] x;
    logic [15:0] y;
  } hop_req_t;

  typedef struct packed {
    status_t     st;
    logic [31:0] hop;
    logic [16:0] hop_dist;
  } hop_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = 1'b0;
  logic [31:0] item_addr = '0;
  logic [15:0] pos_x = '0;
  logic [15:0] pos_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [31:0] next_hop_addr;
  logic [16:0] next_hop_distance;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  greedy_geo_next_hop dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // neighbor table copy and node registers
  logic        nb_valid [ENTRIES];
  logic [31:0] nb_addr [ENTRIES];
  logic [15:0] nb_x [ENTRIES];
  logic [15:0] nb_y [ENTRIES];
  logic [31:0] node_addr;
  logic [15:0] node_x, node_y;

  hop_req_t pending_items[$];
  hop_rsp_t expected_hops[$];
  int       errors = 0;
  int       cycles = 0;
  int       gap_left = 0, burst_left = 0, stall_left = 0;
  logic     feeding = 1'b1;
  logic [31:0] known_addrs[$];

  function automatic logic [16:0] floor_sqrt(logic [33:0] v);
    logic [33:0] r;
    logic [33:0] t;
    r = '0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (34'd1 << b);
      if (t * t <= v) r = t;
    end
    return r[16:0];
  endfunction

  function automatic logic [16:0] geo_dist(logic [15:0] ax, logic [15:0] ay,
                                           logic [15:0] bx, logic [15:0] by);
    logic [33:0] dx, dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return floor_sqrt(dx * dx + dy * dy);
  endfunction

  function automatic hop_rsp_t route_item(hop_req_t it);
    hop_rsp_t r;
    int hit, slot;
    logic [16:0] best, d;
    logic found;
    r = '{st: ST_DEAD, hop: '0, hop_dist: '0};
    if (it.op == OP_ADV) begin
      hit = -1;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (nb_valid[i]) begin
          if (hit < 0 && nb_addr[i] == it.addr) hit = i;
        end else if (slot < 0) begin
          slot = i;
        end
      end
      if (it.addr == node_addr) r.st = ST_OWN;
      else if (hit >= 0) begin
        if (nb_x[hit] != it.x || nb_y[hit] != it.y) begin
          nb_x[hit] = it.x;
          nb_y[hit] = it.y;
          r.st = ST_UPDATED;
        end else r.st = ST_UNCHANGED;
      end else if (slot >= 0) begin
        nb_valid[slot] = 1'b1;
        nb_addr[slot] = it.addr;
        nb_x[slot] = it.x;
        nb_y[slot] = it.y;
        r.st = ST_ADDED;
      end else r.st = ST_FULL;
    end else begin
      best = geo_dist(node_x, node_y, it.x, it.y);
      found = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (nb_valid[i]) begin
          d = geo_dist(nb_x[i], nb_y[i], it.x, it.y);
          if (d < best || (d == best && (!found || nb_addr[i] < r.hop))) begin
            best = d;
            r.hop = nb_addr[i];
            found = 1'b1;
          end
        end
      end
      if (found) begin
        r.st = ST_HOP;
        r.hop_dist = best;
      end else r.hop = '0;
    end
    return r;
  endfunction

  // driver: bursts and gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_hops.insert(expected_hops.size(), route_item(pending_items.pop_front()));
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (feeding && pending_items.size() > ((in_valid && !in_stall) ? 0 : 0)
                     && pending_items.size() > 0) begin
          in_valid <= 1'b1;
          opcode <= pending_items[0].op;
          item_addr <= pending_items[0].addr;
          pos_x <= pending_items[0].x;
          pos_y <= pending_items[0].y;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern and result check
  always @(posedge clk) begin
    hop_rsp_t e;
    cycles <= cycles + 1;
    if (!rst) begin
      if (stall_left > 0) stall_left <= stall_left - 1;
      else begin
        out_stall <= ~out_stall;
        stall_left <= out_stall ? $urandom_range(0, 60) : $urandom_range(0, 8);
      end
      if (out_valid && !out_stall) begin
        if (expected_hops.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          e = expected_hops.pop_front();
          if (status !== e.st) begin
            $error("status exp %0d got %0d", e.st, status);
            errors++;
          end
          if (next_hop_addr !== e.hop) begin
            $error("next_hop_addr exp %h got %h", e.hop, next_hop_addr);
            errors++;
          end
          if (next_hop_distance !== e.hop_dist) begin
            $error("next_hop_distance exp %0d got %0d", e.hop_dist, next_hop_distance);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYC) begin
      $display("greedy_geo_next_hop verification failed");
      $finish;
    end
  end

  task automatic add_item(logic op, logic [31:0] a, logic [15:0] x, logic [15:0] y);
    pending_items.insert(pending_items.size(), hop_req_t'{op: op, addr: a, x: x, y: y});
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      CFG_OWN_ADDR: node_addr = v;
      CFG_OWN_X: node_x = v[15:0];
      default: node_y = v[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_hops.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // random phase: well-formed advertise/query mix, advertisements partly reusing known addresses
  task automatic random_phase(int n);
    logic [31:0] a;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          a = (known_addrs.size() > 0 && $urandom_range(0, 1))
              ? known_addrs[$urandom_range(0, known_addrs.size() - 1)] : $urandom;
          if ($urandom_range(0, 15) == 0) a = node_addr;
          known_addrs.insert(known_addrs.size(), a);
          add_item(OP_ADV, a, 16'($urandom), 16'($urandom));
        end
        3: add_item(OP_ADV, $urandom, 16'($urandom_range(0, 3)),
                    16'(16'hFFFF - $urandom_range(0, 3)));
        default: add_item(OP_QUERY, $urandom, 16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      nb_valid[i] = 1'b0;
      nb_addr[i] = '0;
      nb_x[i] = '0;
      nb_y[i] = '0;
    end
    node_addr = '0;
    node_x = '0;
    node_y = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: empty table, own address, extremes, ties, update, full table
    add_item(OP_QUERY, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    add_item(OP_ADV, 32'h0, 16'h1, 16'h1);
    add_item(OP_ADV, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    add_item(OP_ADV, 32'h5, 16'hFFFF, 16'hFFFF);
    add_item(OP_ADV, 32'h5, 16'hFFFF, 16'hFFFF);
    add_item(OP_ADV, 32'hFFFF_FFFF, 16'h0, 16'hFFFF);
    add_item(OP_QUERY, 32'h0, 16'hFFFF, 16'hFFFF);
    add_item(OP_QUERY, 32'h0, 16'h0, 16'h0);
    for (int i = 0; i < 15; i++) add_item(OP_ADV, 32'h100 + i, 16'h8000, 16'h8000);
    add_item(OP_QUERY, 32'h0, 16'h8000, 16'h8000);
    add_item(OP_ADV, 32'hAAAA_5555, 16'h1234, 16'h4321);
    drain();
    write_reg(CFG_OWN_ADDR, 32'hFFFF_FFFF);
    write_reg(CFG_OWN_X, 32'hFFFF);
    write_reg(CFG_OWN_Y, 32'hFFFF);
    add_item(OP_ADV, 32'hFFFF_FFFF, 16'h0, 16'h0);
    add_item(OP_QUERY, 32'h0, 16'hFFFF, 16'hFFFF);
    add_item(OP_QUERY, 32'h0, 16'h0, 16'h0);
    drain();
    // fresh tables are not reachable without reset, so later phases query and
    // update the full table while own position and address move around
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_OWN_ADDR, (p == 5) ? 32'h0 : $urandom);
      write_reg(CFG_OWN_X, (p == 4) ? 32'h0 : $urandom_range(0, 65535));
      write_reg(CFG_OWN_Y, (p == 4) ? 32'hFFFF : $urandom_range(0, 65535));
      for (int i = 0; i < ENTRIES; i++)
        if (nb_valid[i]) known_addrs.insert(known_addrs.size(), nb_addr[i]);
      random_phase(150);
      drain();
    end
    if (errors == 0) $display("greedy_geo_next_hop verification clean");
    else $display("greedy_geo_next_hop verification failed");
    $finish;
  end

endmodule

FILE: greedy_geo_next_hop.f
hdl/ggnh_pkg.sv
hdl/ggnh_isqrt.sv
hdl/greedy_geo_next_hop.sv
tb/sv/tb_top.sv
